@@ rtl/epve_pkg.sv @@
// Shared constants, types and helper functions of the encoder velocity estimator.
package epve_pkg;

    localparam int FRACTION_BITS = 16;

    localparam int EST_W  = 48;
    localparam int CNT_W  = 32;
    localparam int US_W   = 16;
    localparam int CFG_W  = 32;
    localparam int DT_W   = 29;
    localparam int KDT_W  = DT_W + CFG_W;
    localparam int MAG_W  = 64;
    localparam int PROD_W = 2 * MAG_W;
    localparam int ERR_W  = EST_W + 1;
    localparam int SH_W   = 7;
    localparam int DIG_W  = 16;
    localparam int DIGITS = MAG_W / DIG_W;

    localparam logic [SH_W-1:0] SH_DT   = SH_W'(32);
    localparam logic [SH_W-1:0] SH_GAIN = SH_W'(48 - FRACTION_BITS);
    localparam logic [SH_W-1:0] SH_OUT  = SH_W'(FRACTION_BITS + 16);

    localparam logic signed [MAG_W-1:0] EST_MAX = (MAG_W'(64'sd1) <<< (EST_W - 1)) - 1;
    localparam logic signed [MAG_W-1:0] EST_MIN = -EST_MAX - 1;

    typedef struct packed {
        logic                    load;
        logic signed [CNT_W-1:0] count;
        logic [DT_W-1:0]         dt;
        logic [KDT_W-1:0]        kdt_p;
        logic [KDT_W-1:0]        kdt_i;
        logic [CFG_W-1:0]        rad;
        logic [CFG_W-1:0]        mm;
    } t_lane_cmd;

    typedef struct packed {
        logic signed [EST_W-1:0] rad;
        logic signed [EST_W-1:0] mm;
    } t_lane_res;

    function automatic logic signed [EST_W-1:0] sat_est(input logic signed [MAG_W-1:0] x);
        logic signed [MAG_W-1:0] y;
        y = x;
        if (x > EST_MAX) y = EST_MAX;
        if (x < EST_MIN) y = EST_MIN;
        return y[EST_W-1:0];
    endfunction

    function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W-1:0] x);
        logic signed [MAG_W-1:0] n;
        n = -x;
        return x[MAG_W-1] ? $unsigned(n) : $unsigned(x);
    endfunction

endpackage

@@ rtl/epve_scale.sv @@
// Digit-serial product with round-half-away, shift and 48-bit saturation.
module epve_scale import epve_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_neg,
    input  logic [MAG_W-1:0]        i_ma,
    input  logic [MAG_W-1:0]        i_mb,
    input  logic [SH_W-1:0]         i_sh,
    output logic                    o_done,
    output logic signed [EST_W-1:0] o_res
);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_MUL  = 2'd1;
    localparam logic [1:0] P_RND  = 2'd2;
    localparam logic [1:0] P_SAT  = 2'd3;
    localparam int CNT_B = $clog2(DIGITS);

    logic [1:0]             r_ph;
    logic [CNT_B-1:0]       r_cnt;
    logic [MAG_W-1:0]       r_a;
    logic [MAG_W-1:0]       r_b;
    logic [PROD_W-1:0]      r_acc;
    logic                   r_neg;
    logic [SH_W-1:0]        r_sh;
    logic                   r_done;
    logic signed [EST_W-1:0] r_res;

    logic [MAG_W+DIG_W-1:0] w_pp;
    logic [PROD_W-1:0]      w_q;
    logic [PROD_W-1:0]      w_lim;
    logic [EST_W-1:0]       w_qs;

    assign w_pp  = r_a * r_b[MAG_W-1 -: DIG_W];
    assign w_q   = r_acc >> r_sh;
    assign w_lim = r_neg ? (PROD_W'(1) << (EST_W - 1)) : ((PROD_W'(1) << (EST_W - 1)) - 1);
    assign w_qs  = (w_q > w_lim) ? w_lim[EST_W-1:0] : w_q[EST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= P_IDLE;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_ph)
                P_IDLE: begin
                    if (i_start) begin
                        r_a   <= i_ma;
                        r_b   <= i_mb;
                        r_neg <= i_neg;
                        r_sh  <= i_sh;
                        r_acc <= '0;
                        r_cnt <= '0;
                        r_ph  <= P_MUL;
                    end
                end
                P_MUL: begin
                    // most significant digit first
                    r_acc <= (r_acc << DIG_W) + PROD_W'(w_pp);
                    r_b   <= r_b << DIG_W;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_B'(DIGITS - 1)) r_ph <= P_RND;
                end
                P_RND: begin
                    r_acc <= r_acc + (PROD_W'(1) << (r_sh - 1'b1));
                    r_ph  <= P_SAT;
                end
                P_SAT: begin
                    r_res  <= r_neg ? -$signed(w_qs) : $signed(w_qs);
                    r_done <= 1'b1;
                    r_ph   <= P_IDLE;
                end
                default: r_ph <= P_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

@@ rtl/epve_lane.sv @@
// One tracking-loop lane: position and velocity estimates plus speed scaling.
module epve_lane import epve_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_lane_cmd i_cmd,
    output logic      o_done,
    output t_lane_res o_res
);

    localparam logic [3:0] L_IDLE = 4'd0;
    localparam logic [3:0] L_DTS  = 4'd1;
    localparam logic [3:0] L_DTW  = 4'd2;
    localparam logic [3:0] L_ERR  = 4'd3;
    localparam logic [3:0] L_KPS  = 4'd4;
    localparam logic [3:0] L_KPW  = 4'd5;
    localparam logic [3:0] L_KIS  = 4'd6;
    localparam logic [3:0] L_KIW  = 4'd7;
    localparam logic [3:0] L_SNAP = 4'd8;
    localparam logic [3:0] L_RS   = 4'd9;
    localparam logic [3:0] L_RW   = 4'd10;
    localparam logic [3:0] L_MS   = 4'd11;
    localparam logic [3:0] L_MW   = 4'd12;

    logic [3:0]              r_state;
    t_lane_cmd               r_cmd;
    logic signed [EST_W-1:0] r_pos;
    logic signed [EST_W-1:0] r_vel;
    logic signed [ERR_W-1:0] r_err;
    logic                    r_done;
    t_lane_res               r_res;

    logic                    w_start;
    logic                    w_neg;
    logic [MAG_W-1:0]        w_ma;
    logic [MAG_W-1:0]        w_mb;
    logic [SH_W-1:0]         w_sh;
    logic                    w_mdone;
    logic signed [EST_W-1:0] w_mres;
    logic [MAG_W-1:0]        w_mv;
    logic signed [EST_W-1:0] w_fl;

    always_comb begin
        w_start = 1'b0;
        w_neg   = 1'b0;
        w_ma    = '0;
        w_mb    = '0;
        w_sh    = SH_DT;
        case (r_state)
            L_DTS: begin
                w_start = 1'b1;
                w_neg   = r_vel[EST_W-1];
                w_ma    = mag(MAG_W'(r_vel));
                w_mb    = MAG_W'(r_cmd.dt);
                w_sh    = SH_DT;
            end
            L_KPS, L_KIS: begin
                w_start = 1'b1;
                w_neg   = r_err[ERR_W-1];
                w_ma    = mag(MAG_W'(r_err));
                w_mb    = (r_state == L_KPS) ? MAG_W'(r_cmd.kdt_p) : MAG_W'(r_cmd.kdt_i);
                w_sh    = SH_GAIN;
            end
            L_RS, L_MS: begin
                w_start = 1'b1;
                w_neg   = r_vel[EST_W-1];
                w_ma    = mag(MAG_W'(r_vel));
                w_mb    = (r_state == L_RS) ? MAG_W'(r_cmd.rad) : MAG_W'(r_cmd.mm);
                w_sh    = SH_OUT;
            end
            default: ;
        endcase
    end

    epve_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_neg   (w_neg),
        .i_ma    (w_ma),
        .i_mb    (w_mb),
        .i_sh    (w_sh),
        .o_done  (w_mdone),
        .o_res   (w_mres)
    );

    assign w_mv = mag(MAG_W'(r_vel));
    assign w_fl = r_pos >>> FRACTION_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_pos   <= '0;
            r_vel   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_cmd <= i_cmd;
                        if (i_cmd.load) begin
                            r_pos  <= sat_est(MAG_W'(i_cmd.count) <<< FRACTION_BITS);
                            r_done <= 1'b1;
                        end else begin
                            r_state <= L_DTS;
                        end
                    end
                end
                L_DTS: r_state <= L_DTW;
                L_DTW: begin
                    if (w_mdone) begin
                        r_pos   <= sat_est(MAG_W'(r_pos) + MAG_W'(w_mres));
                        r_state <= L_ERR;
                    end
                end
                L_ERR: begin
                    // count minus floor of the estimate
                    r_err   <= ERR_W'(r_cmd.count) - ERR_W'(w_fl);
                    r_state <= L_KPS;
                end
                L_KPS: r_state <= L_KPW;
                L_KPW: begin
                    if (w_mdone) begin
                        r_pos   <= sat_est(MAG_W'(r_pos) + MAG_W'(w_mres));
                        r_state <= L_KIS;
                    end
                end
                L_KIS: r_state <= L_KIW;
                L_KIW: begin
                    if (w_mdone) begin
                        r_vel   <= sat_est(MAG_W'(r_vel) + MAG_W'(w_mres));
                        r_state <= L_SNAP;
                    end
                end
                L_SNAP: begin
                    // snap to zero below half of ki*dt
                    if (w_mv < (MAG_W'(1) << (12 + FRACTION_BITS)) &&
                        (w_mv << (49 - FRACTION_BITS)) < MAG_W'(r_cmd.kdt_i))
                        r_vel <= '0;
                    r_state <= L_RS;
                end
                L_RS: r_state <= L_RW;
                L_RW: begin
                    if (w_mdone) begin
                        r_res.rad <= w_mres;
                        r_state   <= L_MS;
                    end
                end
                L_MS: r_state <= L_MW;
                L_MW: begin
                    if (w_mdone) begin
                        r_res.mm <= w_mres;
                        r_done   <= 1'b1;
                        r_state  <= L_IDLE;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

@@ rtl/encoder_pll_velocity_estimator_top.sv @@
// Top level: request intake, dt stage, gain products, two lanes and result merge.
// Tracking tick: the dt stages T_DIV, T_REC and T_DT, the gain stage, the lane start, two
//   lanes with five products each, and the merge once the output register is free.
// Loading tick (first after reset): presets the positions and returns zero speeds. One tick
//   in flight at a time; the next request is taken while a result waits in the output register.
// Reset (synchronous, active low) clears the estimates, the started flag and all
//   control; the gain and scale registers return to their default values.
module encoder_pll_velocity_estimator_top import epve_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input requests
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // [31:0] left_count, [63:32] right_count, [79:64] elapsed_us
    input  logic [79:0]         i_s_tdata,
    // results
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // [47:0] left_speed_rad, [95:48] left_speed_mm,
    // [143:96] right_speed_rad, [191:144] right_speed_mm
    output logic [191:0]        o_m_tdata,
    // [0] speeds_valid
    output logic                o_m_tuser,
    // configuration writes
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    localparam logic [7:0] REG_KP  = 8'd0;
    localparam logic [7:0] REG_KI  = 8'd1;
    localparam logic [7:0] REG_RAD = 8'd2;
    localparam logic [7:0] REG_MM  = 8'd3;

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_DIV  = 3'd1;
    localparam logic [2:0] T_GAIN = 3'd2;
    localparam logic [2:0] T_LANE = 3'd3;
    localparam logic [2:0] T_WAIT = 3'd4;
    localparam logic [2:0] T_OUT  = 3'd5;
    localparam logic [2:0] T_REC  = 3'd6;
    localparam logic [2:0] T_DT   = 3'd7;

    // dt = round(us * 2^32 / 1e6). With us * 2^32 = us * 4294 * 1e6 + us * 967296:
    //   dt = us * 4294 + floor((us * 15114 + 7812) / 15625)
    // the last quotient by reciprocal multiplication, exact for 30-bit dividends
    localparam int X_W      = 30;
    localparam int PRD_W    = 61;
    localparam int RECIP_SH = 44;
    localparam logic [13:0] DT_FRAC_MUL  = 14'd15114;
    localparam logic [12:0] DT_FRAC_BIAS = 13'd7812;
    localparam logic [12:0] DT_INT_MUL   = 13'd4294;
    localparam logic [30:0] DT_RECIP     = 31'd1125899907;

    logic [CFG_W-1:0]        r_kp;
    logic [CFG_W-1:0]        r_ki;
    logic [CFG_W-1:0]        r_rad;
    logic [CFG_W-1:0]        r_mm;

    logic [2:0]              r_state;
    logic                    r_started;
    logic                    r_load;
    logic signed [CNT_W-1:0] r_lc;
    logic signed [CNT_W-1:0] r_rc;
    logic [US_W-1:0]         r_us;
    logic [X_W-1:0]          r_x;
    logic [DT_W-1:0]         r_base;
    logic [PRD_W-1:0]        r_prod;
    logic [DT_W-1:0]         r_dt;
    logic [KDT_W-1:0]        r_kdt_p;
    logic [KDT_W-1:0]        r_kdt_i;
    logic                    r_ldone;
    logic                    r_rdone;

    logic                    r_out_valid;
    logic [191:0]            r_out_data;
    logic                    r_out_user;

    logic                    w_accept;
    logic                    w_merge;
    logic                    w_lane_start;
    t_lane_cmd               w_lcmd;
    t_lane_cmd               w_rcmd;
    logic                    w_ldone;
    logic                    w_rdone;
    t_lane_res               w_lres;
    t_lane_res               w_rres;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp  <= CFG_W'(6553600);
            r_ki  <= CFG_W'(163840000);
            r_rad <= '0;
            r_mm  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_KP:  r_kp  <= i_cfg_data;
                REG_KI:  r_ki  <= i_cfg_data;
                REG_RAD: r_rad <= i_cfg_data;
                REG_MM:  r_mm  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_s_tready   = (r_state == T_IDLE);
    assign w_accept     = i_s_tvalid && o_s_tready;
    assign w_lane_start = (r_state == T_LANE);
    // output register is free, or its result leaves this cycle
    assign w_merge      = (r_state == T_OUT) && (!r_out_valid || i_m_tready);

    always_comb begin
        w_lcmd.load  = r_load;
        w_lcmd.count = r_lc;
        w_lcmd.dt    = r_dt;
        w_lcmd.kdt_p = r_kdt_p;
        w_lcmd.kdt_i = r_kdt_i;
        w_lcmd.rad   = r_rad;
        w_lcmd.mm    = r_mm;
        w_rcmd       = w_lcmd;
        w_rcmd.count = r_rc;
    end

    epve_lane u_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_lane_start),
        .i_cmd   (w_lcmd),
        .o_done  (w_ldone),
        .o_res   (w_lres)
    );

    epve_lane u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_lane_start),
        .i_cmd   (w_rcmd),
        .o_done  (w_rdone),
        .o_res   (w_rres)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_started   <= 1'b0;
            r_load      <= 1'b0;
            r_ldone     <= 1'b0;
            r_rdone     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_merge) begin
                r_out_valid <= 1'b1;
            end else if (o_m_tvalid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                T_IDLE: begin
                    if (w_accept) begin
                        r_lc   <= i_s_tdata[31:0];
                        r_rc   <= i_s_tdata[63:32];
                        r_us   <= i_s_tdata[79:64];
                        r_load <= !r_started;
                        r_state <= r_started ? T_DIV : T_LANE;
                    end
                end
                T_DIV: begin
                    r_x     <= X_W'(r_us) * X_W'(DT_FRAC_MUL) + X_W'(DT_FRAC_BIAS);
                    r_base  <= DT_W'(r_us) * DT_W'(DT_INT_MUL);
                    r_state <= T_REC;
                end
                T_REC: begin
                    r_prod  <= PRD_W'(r_x) * PRD_W'(DT_RECIP);
                    r_state <= T_DT;
                end
                T_DT: begin
                    r_dt    <= r_base + DT_W'(r_prod[PRD_W-1:RECIP_SH]);
                    r_state <= T_GAIN;
                end
                T_GAIN: begin
                    r_kdt_p <= r_kp * r_dt;
                    r_kdt_i <= r_ki * r_dt;
                    r_state <= T_LANE;
                end
                T_LANE: begin
                    r_ldone <= 1'b0;
                    r_rdone <= 1'b0;
                    r_state <= T_WAIT;
                end
                T_WAIT: begin
                    if (w_ldone) r_ldone <= 1'b1;
                    if (w_rdone) r_rdone <= 1'b1;
                    if ((r_ldone || w_ldone) && (r_rdone || w_rdone)) r_state <= T_OUT;
                end
                T_OUT: begin
                    // merge both lanes into the output register once it is free
                    if (w_merge) begin
                        r_out_user  <= !r_load;
                        r_out_data  <= r_load ? '0 :
                            {w_rres.mm, w_rres.rad, w_lres.mm, w_lres.rad};
                        r_started   <= 1'b1;
                        r_state     <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != T_IDLE)
        else $error("request accepted but sequencer stayed idle");
    a_load_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> o_m_tdata == '0)
        else $error("loading result carries nonzero speeds");
    a_started_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |=> r_started)
        else $error("started flag dropped");
`endif

endmodule
